// File: rtl/core/cjpr_pkg.sv
`timescale 1ns / 1ps

package cjpr_pkg;

  // request kinds on the input stream
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // result kinds on the output stream
  localparam logic KIND_CAMERA = 1'b0;
  localparam logic KIND_STORE  = 1'b1;

  // acknowledge framing
  localparam logic [7:0] ACK_SYNC  = 8'hAA;
  localparam logic [7:0] ACK_ID    = 8'h0E;
  localparam logic [7:0] ACK_ZERO  = 8'h00;
  localparam logic [7:0] ACK_CLOSE = 8'hF0;
  localparam int         ACK_BYTES = 6;
  localparam int         ACK_POS_W = $clog2(ACK_BYTES);

  // payload bytes per camera packet
  localparam int PACKET_DATA_BYTES = 506;

  // counter widths
  localparam int PKT_NUM_W   = 16;
  localparam int SIZE_W      = 24;
  localparam int TOTAL_W     = 25;
  localparam int LEN_W       = 16;
  localparam int BOUND_W     = PKT_NUM_W + 1 + $clog2(PACKET_DATA_BYTES + 1);

  // command queue between parser and emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       is_ack;   // 1: six-byte acknowledge, 0: one payload byte
    logic [7:0] b0;       // payload byte, or id low byte of acknowledge
    logic [7:0] b1;       // id high byte of acknowledge
    logic       closing;  // closing acknowledge: flag done on final byte
    logic       err;      // checksum failure, with closing
  } cmd_t;

endpackage

// File: rtl/core/camera_jpeg_packet_receiver.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tuser: req_type; s_tdata[7:0]: rx_byte
// m_*       out  m_tvalid/m_tready   m_tuser: out_kind; m_tlast: last;
//                                    m_tdata: out_byte, done_res, error
//
// One input transaction is taken per cycle while the command queue has room.
// Each transaction yields at most one queued command; the emitter drains a
// payload command as one output byte and an acknowledge as six bytes, so
// acknowledges set the output rate. The queue is four commands deep.
// rst is synchronous and returns the parser to idle with the queue empty.
// A stalled output holds its register and lets the queue absorb input.

module camera_jpeg_packet_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] done_res, [9] error, rest zero
  output logic        m_tuser,   // [0] out_kind
  output logic        m_tlast
);

  logic           accept;
  logic           push;
  cjpr_pkg::cmd_t push_cmd;
  logic           full;
  logic           pop;
  logic           not_empty;
  cjpr_pkg::cmd_t head;

  // take a transaction whenever the queue can hold what it may produce
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  // parse camera bytes, track packet bookkeeping, issue commands
  cjpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (s_tuser),
    .rx_byte  (s_tdata),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouple parsing from emission
  cjpr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // expand commands into output bytes through a registered stage
  cjpr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_head   (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/core/cjpr_fifo.sv
`timescale 1ns / 1ps

module cjpr_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cjpr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output cjpr_pkg::cmd_t head
);

  cjpr_pkg::cmd_t                 entries [cjpr_pkg::QUEUE_DEPTH];
  logic [cjpr_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [cjpr_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [cjpr_pkg::QUEUE_AW:0]    count;

  assign full      = (count == (cjpr_pkg::QUEUE_AW + 1)'(cjpr_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == (cjpr_pkg::QUEUE_AW)'(cjpr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == (cjpr_pkg::QUEUE_AW)'(cjpr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/cjpr_front.sv
`timescale 1ns / 1ps

module cjpr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           req_type,
  input  logic [7:0]     rx_byte,
  output logic           push,
  output cjpr_pkg::cmd_t push_cmd
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIZE,
    PH_HDR,
    PH_PAY,
    PH_TRL
  } phase_t;

  phase_t                              phase, phase_next;
  logic [cjpr_pkg::LEN_W-1:0]          byte_index, byte_index_next;
  logic [cjpr_pkg::SIZE_W-1:0]         image_size, image_size_next;
  logic [cjpr_pkg::TOTAL_W-1:0]        received_total, received_total_next;
  logic [cjpr_pkg::PKT_NUM_W-1:0]      packet_number, packet_number_next;
  logic [cjpr_pkg::BOUND_W-1:0]        bound, bound_next;
  logic [cjpr_pkg::LEN_W-1:0]          packet_length, packet_length_next;
  logic [7:0]                          running_sum, running_sum_next;
  logic                                sum_mismatch, sum_mismatch_next;
  logic [cjpr_pkg::LEN_W:0]            index_inc;

  assign index_inc = {1'b0, byte_index} + 1'b1;

  // bound holds PACKET_DATA_BYTES * (packet_number + 1): the transfer ends once
  // the image size falls below it, which matches the packet index passing
  // size / PACKET_DATA_BYTES without a divider
  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    image_size_next     = image_size;
    received_total_next = received_total;
    packet_number_next  = packet_number;
    bound_next          = bound;
    packet_length_next  = packet_length;
    running_sum_next    = running_sum;
    sum_mismatch_next   = sum_mismatch;
    push                = 1'b0;
    push_cmd            = '0;

    if (accept) begin
      if (req_type == cjpr_pkg::REQ_START) begin
        phase_next          = PH_SIZE;
        byte_index_next     = '0;
        image_size_next     = '0;
        received_total_next = '0;
        packet_number_next  = '0;
        bound_next          = (cjpr_pkg::BOUND_W)'(cjpr_pkg::PACKET_DATA_BYTES);
        packet_length_next  = '0;
        running_sum_next    = '0;
        sum_mismatch_next   = 1'b0;
      end else begin
        case (phase)
          PH_SIZE: begin
            if (byte_index == 16'd3) image_size_next[7:0]   = rx_byte;
            if (byte_index == 16'd4) image_size_next[15:8]  = rx_byte;
            if (byte_index == 16'd5) image_size_next[23:16] = rx_byte;
            byte_index_next = index_inc[cjpr_pkg::LEN_W-1:0];
            if (byte_index == 16'd5) begin
              received_total_next = '0;
              packet_number_next  = '0;
              bound_next = (cjpr_pkg::BOUND_W)'(cjpr_pkg::PACKET_DATA_BYTES);
              push = 1'b1;
              if (image_size_next == '0) begin
                phase_next       = PH_IDLE;
                byte_index_next  = '0;
                push_cmd.is_ack  = 1'b1;
                push_cmd.b0      = cjpr_pkg::ACK_CLOSE;
                push_cmd.b1      = cjpr_pkg::ACK_CLOSE;
                push_cmd.closing = 1'b1;
              end else begin
                phase_next         = PH_HDR;
                byte_index_next    = '0;
                running_sum_next   = '0;
                packet_length_next = '0;
                sum_mismatch_next  = 1'b0;
                push_cmd.is_ack    = 1'b1;
              end
            end
          end
          PH_HDR: begin
            running_sum_next = running_sum + rx_byte;
            if (byte_index == 16'd2) packet_length_next[7:0]  = rx_byte;
            if (byte_index == 16'd3) packet_length_next[15:8] = rx_byte;
            byte_index_next = index_inc[cjpr_pkg::LEN_W-1:0];
            if (byte_index == 16'd3) begin
              received_total_next = received_total +
                                    (cjpr_pkg::TOTAL_W)'(packet_length_next);
              byte_index_next = '0;
              phase_next = (packet_length_next == '0) ? PH_TRL : PH_PAY;
            end
          end
          PH_PAY: begin
            running_sum_next = running_sum + rx_byte;
            push             = 1'b1;
            push_cmd.is_ack  = 1'b0;
            push_cmd.b0      = rx_byte;
            if (index_inc >= {1'b0, packet_length}) begin
              byte_index_next = '0;
              phase_next      = PH_TRL;
            end else begin
              byte_index_next = index_inc[cjpr_pkg::LEN_W-1:0];
            end
          end
          PH_TRL: begin
            if (byte_index == '0) begin
              sum_mismatch_next = (running_sum != rx_byte);
              byte_index_next   = 16'd1;
            end else begin
              push            = 1'b1;
              push_cmd.is_ack = 1'b1;
              if (sum_mismatch ||
                  (packet_number == '1) ||
                  ((cjpr_pkg::BOUND_W)'(image_size) < bound) ||
                  (received_total >= (cjpr_pkg::TOTAL_W)'(image_size))) begin
                phase_next       = PH_IDLE;
                byte_index_next  = '0;
                push_cmd.b0      = cjpr_pkg::ACK_CLOSE;
                push_cmd.b1      = cjpr_pkg::ACK_CLOSE;
                push_cmd.closing = 1'b1;
                push_cmd.err     = sum_mismatch;
              end else begin
                packet_number_next = packet_number + 1'b1;
                bound_next = bound + (cjpr_pkg::BOUND_W)'(cjpr_pkg::PACKET_DATA_BYTES);
                phase_next         = PH_HDR;
                byte_index_next    = '0;
                running_sum_next   = '0;
                packet_length_next = '0;
                sum_mismatch_next  = 1'b0;
                push_cmd.b0        = packet_number_next[7:0];
                push_cmd.b1        = packet_number_next[15:8];
              end
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_index     <= '0;
      image_size     <= '0;
      received_total <= '0;
      packet_number  <= '0;
      bound          <= (cjpr_pkg::BOUND_W)'(cjpr_pkg::PACKET_DATA_BYTES);
      packet_length  <= '0;
      running_sum    <= '0;
      sum_mismatch   <= 1'b0;
    end else begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      image_size     <= image_size_next;
      received_total <= received_total_next;
      packet_number  <= packet_number_next;
      bound          <= bound_next;
      packet_length  <= packet_length_next;
      running_sum    <= running_sum_next;
      sum_mismatch   <= sum_mismatch_next;
    end
  end

endmodule

// File: rtl/core/cjpr_back.sv
`timescale 1ns / 1ps

module cjpr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  cjpr_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [15:0]    m_tdata,
  output logic           m_tuser,
  output logic           m_tlast
);

  cjpr_pkg::cmd_t                 cur;
  logic                           cur_valid;
  logic [cjpr_pkg::ACK_POS_W-1:0] pos;

  cjpr_pkg::cmd_t                 src;
  logic [cjpr_pkg::ACK_POS_W-1:0] src_pos;
  logic                           src_valid;
  logic                           load;
  logic                           item_last;
  logic [7:0]                     item_byte;

  assign src       = cur_valid ? cur : q_head;
  assign src_pos   = cur_valid ? pos : '0;
  assign src_valid = cur_valid || q_valid;
  assign load      = src_valid && (!m_tvalid || m_tready);
  assign q_pop     = load && !cur_valid;
  assign item_last = !src.is_ack ||
                     (src_pos == (cjpr_pkg::ACK_POS_W)'(cjpr_pkg::ACK_BYTES - 1));

  always_comb begin
    if (!src.is_ack) begin
      item_byte = src.b0;
    end else begin
      case (src_pos)
        3'd0:    item_byte = cjpr_pkg::ACK_SYNC;
        3'd1:    item_byte = cjpr_pkg::ACK_ID;
        3'd4:    item_byte = src.b0;
        3'd5:    item_byte = src.b1;
        default: item_byte = cjpr_pkg::ACK_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'd0, item_last && src.closing && src.err,
                  item_last && src.closing, item_byte};
      m_tuser <= src.is_ack ? cjpr_pkg::KIND_CAMERA : cjpr_pkg::KIND_STORE;
      m_tlast <= item_last;
      cur     <= src;
      pos     <= src_pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      cur_valid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid  <= 1'b1;
        cur_valid <= !item_last;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

endmodule
